FILE: hw/rtl/dsu_pkg.sv
// ============================================================================
// dsu_pkg: shared types and constants of the disjoint-set engine
// Holds the command codes, the queued command record and default sizes.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package dsu_pkg;

  // Default number of vertices in the forest.
  localparam int VERTICES_DEFAULT = 1024;

  // Width of a vertex number on the command port.
  localparam int VERTEX_W = 10;

  // Number of commands the queue between front and back can hold.
  localparam int QUEUE_DEPTH = 2;

  // Command classes as the front end hands them to the back end.
  typedef enum logic [1:0] {
    OP_MERGE   = 2'd0,
    OP_ASK     = 2'd1,
    OP_ASK_FAR = 2'd2
  } op_t;

  // One queued command.
  typedef struct packed {
    op_t                 op;
    logic [VERTEX_W-1:0] vertex_a;
    logic [VERTEX_W-1:0] vertex_b;
  } cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dsu_front.sv
// ============================================================================
// dsu_front: command intake and classification
// Accepts commands, checks the vertex range and queues work for the back end.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module dsu_front #(
  parameter int VERTICES = dsu_pkg::VERTICES_DEFAULT
) (
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          mode,
  input  wire logic [dsu_pkg::VERTEX_W-1:0]  vertex_a,
  input  wire logic [dsu_pkg::VERTEX_W-1:0]  vertex_b,
  input  wire logic                          q_full,
  input  wire logic                          clearing,
  output logic                               push,
  output dsu_pkg::cmd_t                      push_entry
);

  logic accept;
  logic in_range;

  // New commands are held off while the queue is full or the tables are cleared.
  assign busy   = q_full | clearing;
  assign accept = start & ~busy;

  // Both vertex numbers must name a vertex of the forest.
  assign in_range = (32'(vertex_a) < 32'(VERTICES)) && (32'(vertex_b) < 32'(VERTICES));

  // Classify the command. A merge that names a missing vertex does nothing,
  // so it is dropped here; an ask that names one is answered without a lookup.
  always_comb begin
    push_entry.vertex_a = vertex_a;
    push_entry.vertex_b = vertex_b;
    push                = 1'b0;
    push_entry.op       = dsu_pkg::OP_MERGE;
    if (mode) begin
      push_entry.op = in_range ? dsu_pkg::OP_ASK : dsu_pkg::OP_ASK_FAR;
      push          = accept;
    end else begin
      push_entry.op = dsu_pkg::OP_MERGE;
      push          = accept & in_range;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/dsu_queue.sv
// ============================================================================
// dsu_queue: command queue between front and back end
// A small circular buffer of classified commands.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module dsu_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire dsu_pkg::cmd_t push_entry,
  output logic               full,
  input  wire logic          pop,
  output dsu_pkg::cmd_t      pop_entry,
  output logic               empty
);

  localparam int D  = dsu_pkg::QUEUE_DEPTH;
  localparam int PW = (D > 1) ? $clog2(D) : 1;
  localparam int CW = $clog2(D + 1);

  dsu_pkg::cmd_t  entries [D];
  logic [PW-1:0]  head;
  logic [PW-1:0]  tail;
  logic [CW-1:0]  count;

  assign full      = (count == CW'(D));
  assign empty     = (count == '0);
  assign pop_entry = entries[head];

  // Storage for queued commands.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[tail] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == PW'(D - 1)) ? '0 : tail + PW'(1);
      end
      if (pop) begin
        head <= (head == PW'(D - 1)) ? '0 : head + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/dsu_back.sv
// ============================================================================
// dsu_back: find, compress and link sequencer
// Owns the parent and size tables and carries out queued commands.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module dsu_back #(
  parameter int VERTICES = dsu_pkg::VERTICES_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_empty,
  input  wire dsu_pkg::cmd_t q_entry,
  output logic               q_pop,
  output logic               clearing,
  output logic               done,
  output logic               connected
);

  localparam int AW = $clog2(VERTICES);
  localparam int SW = $clog2(VERTICES + 1);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_WALK   = 6'b000100,
    S_COMP   = 6'b001000,
    S_SIZE_A = 6'b010000,
    S_SIZE_B = 6'b100000
  } state_t;

  // Tables.
  logic [AW-1:0] parent_mem [VERTICES];
  logic [SW-1:0] size_mem   [VERTICES];

  // Sequencer registers.
  state_t          state, state_next;
  logic [AW-1:0]   clr_idx, clr_idx_next;
  dsu_pkg::op_t    op, op_next;
  logic [AW-1:0]   va, va_next;
  logic [AW-1:0]   vb, vb_next;
  logic            phase, phase_next;
  logic [AW-1:0]   cur, cur_next;
  logic [AW-1:0]   root, root_next;
  logic [AW-1:0]   root_a, root_a_next;
  logic [SW-1:0]   size_a, size_a_next;
  logic            done_next;
  logic            connected_next;

  // Memory ports.
  logic [AW-1:0]   par_ra, par_wa, par_wd, par_rdata;
  logic            par_we;
  logic [AW-1:0]   sz_ra, sz_wa;
  logic [SW-1:0]   sz_wd, sz_rdata;
  logic            sz_we;
  logic [AW-1:0]   start_v;

  assign clearing = (state == S_CLEAR);
  assign start_v  = phase ? vb : va;

  // Parent table: one write and one registered read a cycle.
  always_ff @(posedge clk) begin
    if (par_we) begin
      parent_mem[par_wa] <= par_wd;
    end
    par_rdata <= parent_mem[par_ra];
  end

  // Size table: one write and one registered read a cycle.
  always_ff @(posedge clk) begin
    if (sz_we) begin
      size_mem[sz_wa] <= sz_wd;
    end
    sz_rdata <= size_mem[sz_ra];
  end

  // Next-state logic. The parent read address always names the vertex whose
  // link is examined in the following cycle.
  always_comb begin
    state_next     = state;
    clr_idx_next   = clr_idx;
    op_next        = op;
    va_next        = va;
    vb_next        = vb;
    phase_next     = phase;
    cur_next       = cur;
    root_next      = root;
    root_a_next    = root_a;
    size_a_next    = size_a;
    done_next      = 1'b0;
    connected_next = connected;
    q_pop          = 1'b0;
    par_ra         = cur;
    par_we         = 1'b0;
    par_wa         = cur;
    par_wd         = root;
    sz_ra          = root_a;
    sz_we          = 1'b0;
    sz_wa          = root_a;
    sz_wd          = size_a;

    unique case (state)
      S_CLEAR: begin
        par_we       = 1'b1;
        par_wa       = clr_idx;
        par_wd       = clr_idx;
        sz_we        = 1'b1;
        sz_wa        = clr_idx;
        sz_wd        = SW'(1);
        clr_idx_next = clr_idx + AW'(1);
        if (clr_idx == AW'(VERTICES - 1)) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_entry.op == dsu_pkg::OP_ASK_FAR) begin
            done_next      = 1'b1;
            connected_next = 1'b0;
          end else begin
            op_next    = q_entry.op;
            va_next    = AW'(q_entry.vertex_a);
            vb_next    = AW'(q_entry.vertex_b);
            cur_next   = AW'(q_entry.vertex_a);
            par_ra     = AW'(q_entry.vertex_a);
            phase_next = 1'b0;
            state_next = S_WALK;
          end
        end
      end

      // Follow links until a vertex points at itself.
      S_WALK: begin
        if (par_rdata == cur) begin
          root_next  = cur;
          cur_next   = start_v;
          par_ra     = start_v;
          state_next = S_COMP;
        end else begin
          cur_next = par_rdata;
          par_ra   = par_rdata;
        end
      end

      // Walk the same path again and point each vertex at the root.
      S_COMP: begin
        if (cur == root) begin
          if (!phase) begin
            root_a_next = root;
            phase_next  = 1'b1;
            cur_next    = vb;
            par_ra      = vb;
            state_next  = S_WALK;
          end else if (op == dsu_pkg::OP_ASK) begin
            done_next      = 1'b1;
            connected_next = (root_a == root);
            state_next     = S_IDLE;
          end else if (root_a == root) begin
            state_next = S_IDLE;
          end else begin
            sz_ra      = root_a;
            state_next = S_SIZE_A;
          end
        end else begin
          par_we   = 1'b1;
          par_wa   = cur;
          par_wd   = root;
          cur_next = par_rdata;
          par_ra   = par_rdata;
        end
      end

      S_SIZE_A: begin
        size_a_next = sz_rdata;
        sz_ra       = root;
        state_next  = S_SIZE_B;
      end

      // Hang the smaller set under the larger; a tie keeps the first root.
      S_SIZE_B: begin
        par_we = 1'b1;
        sz_we  = 1'b1;
        sz_wd  = size_a + sz_rdata;
        if (size_a < sz_rdata) begin
          par_wa = root_a;
          par_wd = root;
          sz_wa  = root;
        end else begin
          par_wa = root;
          par_wd = root_a;
          sz_wa  = root_a;
        end
        state_next = S_IDLE;
      end

      default: begin
        state_next   = S_CLEAR;
        clr_idx_next = '0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      clr_idx <= clr_idx_next;
      done    <= done_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    op        <= op_next;
    va        <= va_next;
    vb        <= vb_next;
    phase     <= phase_next;
    cur       <= cur_next;
    root      <= root_next;
    root_a    <= root_a_next;
    size_a    <= size_a_next;
    connected <= connected_next;
  end

  // An ask that names a missing vertex is answered "not connected" at once.
  a_far_answer: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_entry.op == dsu_pkg::OP_ASK_FAR) |=> (done && !connected))
    else $error("out-of-range ask not answered as not connected");

  // Linking only ever joins two distinct roots.
  a_link_roots: assert property (@(posedge clk) disable iff (rst)
    (state == S_SIZE_B) |-> (root_a != root))
    else $error("link of a root to itself");

  // The clearing pass ends only after the last table entry.
  a_clear_len: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == S_CLEAR && state == S_IDLE) |-> ($past(clr_idx) == AW'(VERTICES - 1)))
    else $error("clearing pass ended early");

  // Commands are taken from the queue only between commands.
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state == S_IDLE || state == S_WALK))
    else $error("queue popped while a command was in progress");

endmodule

`default_nettype wire

FILE: hw/rtl/disjoint_set_union_find.sv
// ============================================================================
// disjoint_set_union_find: union-find engine, union by size, path compression
// Front end classifies commands, a queue decouples it from the back end,
// which runs finds with compression and links sets in two tables.
// ============================================================================
//
//  Channel   Ports                          Transfer
//  command   start, mode, vertex_a/b        start high and busy low at a clock edge
//  result    done, connected                done high for one cycle, cannot stall
//
//  A merge or ask in the back end walks from vertex a to its root and compresses
//  that path, then does the same for vertex b; a merge of two different sets then
//  reads both set sizes. Each walk or compression step is one read of the parent
//  table, which sets the pace.
//  After reset a clearing pass over all VERTICES entries initializes the tables;
//  busy is high during it, and also while the two-entry command queue is full.
//  A result is presented in the cycle after its lookup completes.
//
`timescale 1ns / 1ps
`default_nettype none

module disjoint_set_union_find #(
  parameter int VERTICES = dsu_pkg::VERTICES_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          mode,
  input  wire logic [dsu_pkg::VERTEX_W-1:0]  vertex_a,
  input  wire logic [dsu_pkg::VERTEX_W-1:0]  vertex_b,
  output logic                               done,
  output logic                               connected
);

  logic           q_full;
  logic           q_empty;
  logic           q_push;
  logic           q_pop;
  logic           clearing;
  dsu_pkg::cmd_t  push_entry;
  dsu_pkg::cmd_t  pop_entry;

  // Command intake.
  dsu_front #(
    .VERTICES (VERTICES)
  ) u_front (
    .start      (start),
    .busy       (busy),
    .mode       (mode),
    .vertex_a   (vertex_a),
    .vertex_b   (vertex_b),
    .q_full     (q_full),
    .clearing   (clearing),
    .push       (q_push),
    .push_entry (push_entry)
  );

  // Command queue.
  dsu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .empty      (q_empty)
  );

  // Table sequencer.
  dsu_back #(
    .VERTICES (VERTICES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_entry   (pop_entry),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .done      (done),
    .connected (connected)
  );

endmodule

`default_nettype wire

FILE: test/disjoint_set_union_find_tb.sv
// ============================================================================
// disjoint_set_union_find_tb: self-checking bench for the union-find engine
// Merge and ask commands go to the block. A scoreboard class keeps its own
// parent and size tables and computes the connectivity answer of every ask
// when the block takes it. Results are matched in order, one bit at a time.
// ============================================================================
`timescale 1ns / 1ps

module disjoint_set_union_find_tb;

  localparam int NUM_VERTICES = dsu_pkg::VERTICES_DEFAULT;
  localparam int VW           = dsu_pkg::VERTEX_W;
  localparam int CLK_HALF     = 4;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_ITEMS = 1900;
  localparam int DRAIN_CYCLES = 200;
  localparam int REPORT_MAX   = 10;

  // Command encoding on the mode port.
  localparam bit MODE_MERGE = 1'b0;
  localparam bit MODE_ASK   = 1'b1;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          start     = 1'b0;
  logic          mode      = MODE_MERGE;
  logic [VW-1:0] vertex_a  = '0;
  logic [VW-1:0] vertex_b  = '0;
  logic          busy;
  logic          done;
  logic          connected;

  int cycle_count = 0;
  int idle_pct    = 0;
  int merges_sent = 0;
  int asks_sent   = 0;

  // Keeps a private copy of the forest and the answers still owed by the block.
  class connectivity_scoreboard;
    bit [VW-1:0] parent_of [NUM_VERTICES];
    bit [VW:0]   size_of   [NUM_VERTICES];
    bit          expected_connected [$];
    int          errors;
    int          checked;

    function new();
      for (int i = 0; i < NUM_VERTICES; i++) begin
        parent_of[i] = i[VW-1:0];
        size_of[i]   = 1;
      end
      errors  = 0;
      checked = 0;
    endfunction

    function void log_error(string msg);
      errors++;
      if (errors <= REPORT_MAX) begin
        $display("[%0t] mismatch: %s", $realtime, msg);
      end
    endfunction

    // Append one owed answer at the tail of the queue.
    function void queue_answer(bit want);
      expected_connected.insert(expected_connected.size(), want);
    endfunction

    // Walk up to the root, then point every vertex on the path at it.
    function bit [VW-1:0] find_root(bit [VW-1:0] v);
      bit [VW-1:0] r;
      bit [VW-1:0] nxt;
      r = v;
      while (parent_of[r] != r) r = parent_of[r];
      while (v != r) begin
        nxt          = parent_of[v];
        parent_of[v] = r;
        v            = nxt;
      end
      return r;
    endfunction

    // Apply one command that the block has taken and queue its answer.
    function void note_command(bit m, bit [VW-1:0] a, bit [VW-1:0] b);
      bit          in_range;
      bit [VW-1:0] ra;
      bit [VW-1:0] rb;
      bit [VW-1:0] tmp;
      in_range = (a < NUM_VERTICES) && (b < NUM_VERTICES);
      if (m == MODE_MERGE) begin
        if (!in_range) return;
        ra = find_root(a);
        rb = find_root(b);
        if (ra != rb) begin
          // The smaller set goes under the larger; a tie keeps the first root.
          if (size_of[ra] < size_of[rb]) begin
            tmp = ra;
            ra  = rb;
            rb  = tmp;
          end
          parent_of[rb] = ra;
          size_of[ra]   = size_of[ra] + size_of[rb];
        end
      end else if (!in_range) begin
        queue_answer(1'b0);
      end else begin
        ra = find_root(a);
        rb = find_root(b);
        queue_answer(ra == rb);
      end
    endfunction

    function void check_result(bit got);
      bit want;
      if (expected_connected.size() == 0) begin
        log_error($sformatf("connected=%0b arrived with no ask pending", got));
        return;
      end
      want = expected_connected.pop_front();
      checked++;
      if (got !== want) begin
        log_error($sformatf("connected expected %0b, got %0b", want, got));
      end
    endfunction
  endclass

  connectivity_scoreboard board;

  disjoint_set_union_find #(
    .VERTICES (NUM_VERTICES)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .mode      (mode),
    .vertex_a  (vertex_a),
    .vertex_b  (vertex_b),
    .done      (done),
    .connected (connected)
  );

  always #CLK_HALF clk = ~clk;

  // Results cannot be held off, so every strobe is checked at its edge.
  always @(posedge clk) begin
    if (!rst && done && board != null) begin
      board.check_result(connected);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Idle at random, then hold start until the block takes the transfer.
  task automatic issue_command(input bit m, input bit [VW-1:0] a, input bit [VW-1:0] b);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    mode     <= m;
    vertex_a <= a;
    vertex_b <= b;
    do @(posedge clk); while (busy);
    board.note_command(m, a, b);
    if (m == MODE_MERGE) merges_sent++;
    else asks_sent++;
  endtask

  // Mostly vertices near a sliding base so sets grow and asks split both ways.
  function automatic bit [VW-1:0] pick_vertex(int base);
    if ($urandom_range(99) < 20) return VW'($urandom_range(NUM_VERTICES - 1));
    return VW'((base + $urandom_range(63)) % NUM_VERTICES);
  endfunction

  initial begin
    int base;
    board = new();

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: self asks, ties, size ordering and a deep tree.
    idle_pct = 8;
    issue_command(MODE_ASK,   10'd0,    10'd0);
    issue_command(MODE_ASK,   10'd1023, 10'd1023);
    issue_command(MODE_ASK,   10'd0,    10'd1023);
    issue_command(MODE_MERGE, 10'd0,    10'd1023);
    issue_command(MODE_ASK,   10'd1023, 10'd0);
    issue_command(MODE_MERGE, 10'd1023, 10'd0);
    issue_command(MODE_MERGE, 10'd1,    10'd2);
    issue_command(MODE_MERGE, 10'd3,    10'd4);
    issue_command(MODE_MERGE, 10'd1,    10'd3);
    issue_command(MODE_MERGE, 10'd5,    10'd1);
    issue_command(MODE_MERGE, 10'd0,    10'd5);
    issue_command(MODE_ASK,   10'd1023, 10'd4);
    issue_command(MODE_ASK,   10'd682,  10'd341);
    issue_command(MODE_MERGE, 10'd682,  10'd341);
    issue_command(MODE_ASK,   10'd341,  10'd682);
    issue_command(MODE_MERGE, 10'd6,    10'd7);
    issue_command(MODE_MERGE, 10'd8,    10'd9);
    issue_command(MODE_MERGE, 10'd6,    10'd8);
    issue_command(MODE_MERGE, 10'd10,   10'd11);
    issue_command(MODE_MERGE, 10'd12,   10'd13);
    issue_command(MODE_MERGE, 10'd10,   10'd12);
    issue_command(MODE_MERGE, 10'd6,    10'd10);
    issue_command(MODE_ASK,   10'd13,   10'd7);
    issue_command(MODE_ASK,   10'd13,   10'd0);

    // Random part in three idling phases: light, heavy, none.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) idle_pct = 56;
      else if (i == 2 * RANDOM_ITEMS / 3) idle_pct = 0;
      base = ((i / 100) * 48) % NUM_VERTICES;
      issue_command(($urandom_range(99) < 40) ? MODE_MERGE : MODE_ASK,
                    pick_vertex(base), pick_vertex(base));
    end
    start <= 1'b0;

    // Drain the owed answers, then watch for stray strobes.
    while (board.expected_connected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    foreach (board.expected_connected[k]) board.log_error("ask left without an answer");

    $display("Sent %0d merges and %0d asks under light, heavy and no sender idling.",
             merges_sent, asks_sent);
    $display("Checked %0d connectivity answers, %0d errors.", board.checked, board.errors);
    if (board.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
